// File: design/ecct_pkg.sv
// ecct_pkg: constants, types and small helper functions for the epoch to civil time block
// used by ecct_sub, ecct_core and epoch_seconds_to_civil_time_top; no dependencies
`default_nettype none

package ecct_pkg;

  localparam int EpochW = 38;
  localparam int DaysW  = 22;
  localparam int SecsW  = 17;
  localparam int YearW  = 14;
  localparam int ModW   = 9;

  localparam logic [EpochW-1:0] MaxEpoch = 38'd253402300799;

  // seconds per day is 675 << 7; floor(2**41 / 675) divides the upper 31 bits by 675
  localparam logic [31:0]      DayRecip    = 32'd3257812230;
  localparam logic [DaysW-1:0] DayOdd      = 22'd675;
  localparam logic [DaysW-1:0] SecsPerHour = 22'd3600;
  localparam logic [DaysW-1:0] SecsPerMin  = 22'd60;
  localparam logic [DaysW-1:0] Days400     = 22'd146097;
  localparam logic [DaysW-1:0] Days100     = 22'd36524;
  localparam logic [DaysW-1:0] Days4       = 22'd1461;
  localparam logic [DaysW-1:0] Days1       = 22'd365;

  localparam logic [YearW-1:0] EpochYear = 14'd1970;
  localparam logic [YearW-1:0] BaseYear  = 14'd1900;
  localparam logic [YearW-1:0] Span400   = 14'd400;
  localparam logic [YearW-1:0] Span100   = 14'd100;
  localparam logic [YearW-1:0] Span4     = 14'd4;
  localparam logic [YearW-1:0] Span1     = 14'd1;

  localparam logic [ModW-1:0] EpochYearMod = 9'd370;
  localparam logic [ModW:0]   Mod400       = 10'd400;
  localparam logic [2:0]      EpochWeekday = 3'd4;
  localparam logic [3:0]      LastMonth    = 4'd11;
  localparam logic [3:0]      February     = 4'd1;
  localparam logic [5:0]      WeekLen      = 6'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_FIX,
    ST_HOUR,
    ST_MIN,
    ST_Y400,
    ST_Y100,
    ST_Y4,
    ST_Y1,
    ST_MON,
    ST_DONE
  } ecct_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } ecct_stat_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [12:0] years_since_1900;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
  } ecct_result_t;

  // century year that is not a multiple of 400, given year mod 400
  function automatic logic century_common(input logic [ModW-1:0] r);
    return (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
  endfunction

  function automatic logic leap_mod(input logic [ModW-1:0] r);
    return (r[1:0] == 2'd0) && !century_common(r);
  endfunction

  function automatic logic [ModW-1:0] mod_add(input logic [ModW-1:0] r,
                                              input logic [ModW-1:0] k);
    logic [ModW:0] s;
    s = {1'b0, r} + {1'b0, k};
    if (s >= Mod400) begin
      s = s - Mod400;
    end
    return s[ModW-1:0];
  endfunction

  function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [4:0] k);
    logic [5:0] s;
    s = {3'b0, wd} + {1'b0, k};
    for (int i = 0; i < 5; i++) begin
      if (s >= WeekLen) begin
        s = s - WeekLen;
      end
    end
    return s[2:0];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m) inside
      February:                  len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: design/ecct_sub.sv
// ecct_sub: shared compare and subtract unit
// used by ecct_core for the day division, time split, year walk and month walk
`default_nettype none

module ecct_sub (
  input  wire logic [ecct_pkg::DaysW-1:0] a,
  input  wire logic [ecct_pkg::DaysW-1:0] b,
  output logic                            ge,
  output logic [ecct_pkg::DaysW-1:0]      diff
);

  logic [ecct_pkg::DaysW:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign ge   = !full[ecct_pkg::DaysW];
  assign diff = full[ecct_pkg::DaysW-1:0];

endmodule

`default_nettype wire

// File: design/ecct_core.sv
// ecct_core: sequencer and working registers for one conversion
// depends on ecct_pkg and ecct_sub
`default_nettype none

module ecct_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [ecct_pkg::EpochW-1:0]      epoch,
  input  wire logic                             take,
  output ecct_pkg::ecct_stat_t                  stat,
  output ecct_pkg::ecct_result_t                res
);

  ecct_pkg::ecct_state_t state, state_next;

  logic [ecct_pkg::EpochW-1:0]   quo, quo_next;
  logic [ecct_pkg::SecsW-1:0]    secs, secs_next;
  logic [ecct_pkg::DaysW-1:0]    days, days_next;
  logic [ecct_pkg::YearW-1:0]    year, year_next;
  logic [ecct_pkg::ModW-1:0]     ymod, ymod_next;
  logic [2:0]                    wd, wd_next;
  logic [4:0]                    hour_cnt, hour_cnt_next;
  logic [5:0]                    min_cnt, min_cnt_next;
  logic [3:0]                    mon, mon_next;
  logic [8:0]                    yday, yday_next;

  logic [ecct_pkg::DaysW-1:0]    sub_a, sub_b, diff;
  logic                          ge;
  logic                          cent_leap, four_common, leap;
  logic [ecct_pkg::ModW-1:0]     m4;
  logic [4:0]                    mlen;
  logic [ecct_pkg::YearW-1:0]    ysince;
  logic [62:0]                   prod;
  logic [ecct_pkg::DaysW-1:0]    dmul;

  ecct_sub u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .ge   (ge),
    .diff (diff)
  );

  // day count estimate, at most one low
  assign prod = {32'b0, quo[ecct_pkg::EpochW-1:7]} * {31'b0, ecct_pkg::DayRecip};
  assign dmul = days * ecct_pkg::DayOdd;

  // century starting here holds a multiple of 400
  assign cent_leap   = (ymod == '0) || (ymod > 9'd300);
  assign m4          = (ymod + 9'd3) & ~9'd3;
  assign four_common = ecct_pkg::century_common(m4);
  assign leap        = ecct_pkg::leap_mod(ymod);
  assign mlen        = ecct_pkg::month_len(mon, leap);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    quo      <= quo_next;
    secs     <= secs_next;
    days     <= days_next;
    year     <= year_next;
    ymod     <= ymod_next;
    wd       <= wd_next;
    hour_cnt <= hour_cnt_next;
    min_cnt  <= min_cnt_next;
    mon      <= mon_next;
    yday     <= yday_next;
  end

  always_comb begin
    state_next    = state;
    quo_next      = quo;
    secs_next     = secs;
    days_next     = days;
    year_next     = year;
    ymod_next     = ymod;
    wd_next       = wd;
    hour_cnt_next = hour_cnt;
    min_cnt_next  = min_cnt;
    mon_next      = mon;
    yday_next     = yday;
    sub_a         = days;
    sub_b         = '0;
    unique case (state)
      ecct_pkg::ST_IDLE: begin
        if (start) begin
          quo_next      = (epoch > ecct_pkg::MaxEpoch) ? ecct_pkg::MaxEpoch : epoch;
          secs_next     = '0;
          year_next     = ecct_pkg::EpochYear;
          ymod_next     = ecct_pkg::EpochYearMod;
          wd_next       = ecct_pkg::EpochWeekday;
          hour_cnt_next = '0;
          min_cnt_next  = '0;
          mon_next      = '0;
          state_next    = ecct_pkg::ST_MUL;
        end
      end
      ecct_pkg::ST_MUL: begin
        days_next  = prod[62:41];
        state_next = ecct_pkg::ST_REM;
      end
      ecct_pkg::ST_REM: begin
        // remainder is below 1350, so the low bits suffice
        sub_a      = quo[28:7];
        sub_b      = dmul;
        secs_next  = diff[ecct_pkg::SecsW-1:0];
        state_next = ecct_pkg::ST_FIX;
      end
      ecct_pkg::ST_FIX: begin
        sub_a = {5'b0, secs};
        sub_b = ecct_pkg::DayOdd;
        if (ge) begin
          days_next = days + 22'd1;
          secs_next = {diff[9:0], quo[6:0]};
        end else begin
          secs_next = {secs[9:0], quo[6:0]};
        end
        state_next = ecct_pkg::ST_HOUR;
      end
      ecct_pkg::ST_HOUR: begin
        sub_a = {5'b0, secs};
        sub_b = ecct_pkg::SecsPerHour;
        if (ge) begin
          secs_next     = diff[ecct_pkg::SecsW-1:0];
          hour_cnt_next = hour_cnt + 5'd1;
        end else begin
          state_next = ecct_pkg::ST_MIN;
        end
      end
      ecct_pkg::ST_MIN: begin
        sub_a = {5'b0, secs};
        sub_b = ecct_pkg::SecsPerMin;
        if (ge) begin
          secs_next    = diff[ecct_pkg::SecsW-1:0];
          min_cnt_next = min_cnt + 6'd1;
        end else begin
          state_next = ecct_pkg::ST_Y400;
        end
      end
      ecct_pkg::ST_Y400: begin
        sub_b = ecct_pkg::Days400;
        if (ge) begin
          days_next = diff;
          year_next = year + ecct_pkg::Span400;
        end else begin
          state_next = ecct_pkg::ST_Y100;
        end
      end
      ecct_pkg::ST_Y100: begin
        sub_b = ecct_pkg::Days100 + {21'b0, cent_leap};
        if (ge) begin
          days_next = diff;
          year_next = year + ecct_pkg::Span100;
          ymod_next = ecct_pkg::mod_add(ymod, ecct_pkg::Span100[ecct_pkg::ModW-1:0]);
          wd_next   = ecct_pkg::wd_add(wd, 5'd5 + {4'b0, cent_leap});
        end else begin
          state_next = ecct_pkg::ST_Y4;
        end
      end
      ecct_pkg::ST_Y4: begin
        sub_b = ecct_pkg::Days4 - {21'b0, four_common};
        if (ge) begin
          days_next = diff;
          year_next = year + ecct_pkg::Span4;
          ymod_next = ecct_pkg::mod_add(ymod, ecct_pkg::Span4[ecct_pkg::ModW-1:0]);
          wd_next   = ecct_pkg::wd_add(wd, 5'd5 - {4'b0, four_common});
        end else begin
          state_next = ecct_pkg::ST_Y1;
        end
      end
      ecct_pkg::ST_Y1: begin
        sub_b = ecct_pkg::Days1 + {21'b0, leap};
        if (ge) begin
          days_next = diff;
          year_next = year + ecct_pkg::Span1;
          ymod_next = ecct_pkg::mod_add(ymod, ecct_pkg::Span1[ecct_pkg::ModW-1:0]);
          wd_next   = ecct_pkg::wd_add(wd, 5'd1 + {4'b0, leap});
        end else begin
          yday_next  = days[8:0];
          state_next = ecct_pkg::ST_MON;
        end
      end
      ecct_pkg::ST_MON: begin
        sub_b = {17'b0, mlen};
        if (ge && (mon != ecct_pkg::LastMonth)) begin
          days_next = diff;
          mon_next  = mon + 4'd1;
          wd_next   = ecct_pkg::wd_add(wd, mlen);
        end else begin
          state_next = ecct_pkg::ST_DONE;
        end
      end
      ecct_pkg::ST_DONE: begin
        if (take) begin
          state_next = ecct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ecct_pkg::ST_IDLE;
      end
    endcase
  end

  assign ysince = year - ecct_pkg::BaseYear;

  assign stat.idle = (state == ecct_pkg::ST_IDLE);
  assign stat.done = (state == ecct_pkg::ST_DONE);

  assign res.second           = secs[5:0];
  assign res.minute           = min_cnt;
  assign res.hour             = hour_cnt;
  assign res.day_of_month     = days[4:0] + 5'd1;
  assign res.month            = mon;
  assign res.years_since_1900 = ysince[12:0];
  assign res.weekday          = ecct_pkg::wd_add(wd, days[4:0]);
  assign res.day_of_year      = yday;

endmodule

`default_nettype wire

// File: design/epoch_seconds_to_civil_time_top.sv
// channel  direction  handshake           word
// in       input      in_valid/in_stall   epoch_seconds
// out      output     out_valid/out_stall second .. day_of_year (eight fields)
//
// one word takes a reciprocal multiply, a remainder step and a correction step for the days,
// then one step per hour, minute, 400/100/4/1-year span and month walked on one subtractor
// after its result is loaded, the sequencer returns to idle before it can accept the next word
// in_stall is high from the accepted word until its result moves to the output register
// the output register holds a finished word while the next one is being converted
// rst is synchronous and clears the sequencer and out_valid
`default_nettype none

module epoch_seconds_to_civil_time_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [37:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       second,
  output logic [5:0]       minute,
  output logic [4:0]       hour,
  output logic [4:0]       day_of_month,
  output logic [3:0]       month,
  output logic [12:0]      years_since_1900,
  output logic [2:0]       weekday,
  output logic [8:0]       day_of_year
);

  ecct_pkg::ecct_stat_t   stat;
  ecct_pkg::ecct_result_t res;
  logic                   start, load, out_valid_next;

  assign in_stall = !stat.idle;
  assign start    = in_valid && !in_stall;
  assign load     = stat.done && (!out_valid || !out_stall);

  ecct_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .epoch (epoch_seconds),
    .take  (load),
    .stat  (stat),
    .res   (res)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      second           <= res.second;
      minute           <= res.minute;
      hour             <= res.hour;
      day_of_month     <= res.day_of_month;
      month            <= res.month;
      years_since_1900 <= res.years_since_1900;
      weekday          <= res.weekday;
      day_of_year      <= res.day_of_year;
    end
  end

endmodule

`default_nettype wire

// File: design/ecct_checker.sv
// ecct_checker: port-level checks for epoch_seconds_to_civil_time_top
// bound to the top level below; no package dependencies
`default_nettype none

module ecct_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [5:0]  second,
  input wire logic [5:0]  minute,
  input wire logic [4:0]  hour,
  input wire logic [4:0]  day_of_month,
  input wire logic [3:0]  month,
  input wire logic [12:0] years_since_1900,
  input wire logic [2:0]  weekday,
  input wire logic [8:0]  day_of_year
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a word");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month < 4'd12) && (day_of_month != 5'd0) && (weekday < 3'd7) &&
                  (day_of_year < 9'd366) && (years_since_1900 >= 13'd70) &&
                  (years_since_1900 <= 13'd8099))
    else $error("calendar date out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(day_of_year) && $stable(second))
    else $error("stalled output word changed");

endmodule

bind epoch_seconds_to_civil_time_top ecct_checker u_ecct_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .second           (second),
  .minute           (minute),
  .hour             (hour),
  .day_of_month     (day_of_month),
  .month            (month),
  .years_since_1900 (years_since_1900),
  .weekday          (weekday),
  .day_of_year      (day_of_year)
);

`default_nettype wire
